// File: src/ira_pkg.sv
// ira_pkg: shared types, constants and functions for the incremental rotation accumulator.
// Holds the Q2.14 format, the first-quadrant sine table and saturation helpers.
// No dependencies.
`timescale 1ns / 1ps

package ira_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int ELEM_W     = 16;
    localparam int ANGLE_W    = 10;
    localparam int PREV_W     = 11;
    localparam int DIFF_W     = 12;
    localparam int PROD_W     = 2 * ELEM_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int SIN_SH     = 31 - FRAC_BITS;
    localparam int UNIT_INT   = ((1 << FRAC_BITS) > 32767) ? 32767 : (1 << FRAC_BITS);

    localparam logic signed [ELEM_W-1:0] UNIT  = ELEM_W'(UNIT_INT);
    localparam logic signed [ACC_W-1:0]  HALF  = ACC_W'(64'd1 << (FRAC_BITS - 1));

    // Reduction of an angle difference into 0..359
    localparam logic [DIFF_W-1:0] FULL_TURN = DIFF_W'(360);
    localparam logic [DIFF_W-1:0] DIFF_BIAS = DIFF_W'(1080);

    // Request kinds on the input tuser
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_RESET  = 1'b1;

    // Axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;
    localparam logic [1:0] AXIS_DONE = 2'd3;

    typedef logic [ELEM_W-1:0] sin_tab_t [0:90];

    // Sine of a whole-degree angle in 0..90, Taylor series in Q31, rounded to FRAC_BITS
    function automatic logic [ELEM_W-1:0] sin_deg(input int a);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (64'(a) * 64'd9595049034) >> 8;
        x2 = (x * x) >> 31;
        t  = 64'd2147483648;
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd210);
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd156);
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd110);
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd72);
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd42);
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd20);
        t  = 64'd2147483648 - (((x2 * t) >> 31) / 64'd6);
        s  = (x * t) >> 31;
        s  = (s + (64'd1 << (SIN_SH - 1))) >> SIN_SH;
        if (s > 64'd32767) begin
            s = 64'd32767;
        end
        return ELEM_W'(s);
    endfunction

    function automatic sin_tab_t build_sin_table();
        sin_tab_t tab;
        for (int i = 0; i <= 90; i++) begin
            tab[i] = sin_deg(i);
        end
        return tab;
    endfunction

    localparam sin_tab_t SIN_T = build_sin_table();

    // Saturate a shifted accumulator to the element width
    function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(32767);
        lo = -ACC_W'(32768);
        if (v > hi) begin
            return ELEM_W'(hi);
        end else if (v < lo) begin
            return ELEM_W'(lo);
        end
        return v[ELEM_W-1:0];
    endfunction

endpackage

// File: src/incremental_rotation_accumulator.sv
// incremental_rotation_accumulator: top level, sequencer with one shared multiplier.
// Keeps the orientation matrix in two ping-pong register banks.
// Depends on ira_pkg.
`timescale 1ns / 1ps

// Usage
//   Input stream (s_*): tuser = request kind (0 update, 1 reset orientation),
//   tdata = angle_x, angle_y, angle_z (signed whole degrees, 10 bits each).
//   Result stream (m_*): four row transactions of the transposed matrix,
//   tdata = row_index then elem0..elem3 (signed Q2.14), tlast on row 3.
//   Throughput: one item at a time; s_tready is high only while idle.
//   A reset item or a skipped update gives no result; the block stays idle.
//   An update runs, per axis, a step of axis selection and, where that angle
//   changed, angle reduction, a table lookup and one 4x4 product on the
//   shared multiplier, element by element; one more axis-selection step
//   then starts the final product on the same multiplier. The rows are
//   then loaded and sent one by one, each held through any stall.
//   A stalled m_tready holds the current row; the block waits and nothing is
//   lost. aresetn loads identity, clears the angles and the skip flag; no
//   clearing pass is needed as an identity flag covers each matrix bank.
module incremental_rotation_accumulator
    import ira_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // angle_x[9:0], angle_y[19:10], angle_z[29:20], zero pad
    input  logic        s_tuser,   // req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // row_index[1:0], elem0..elem3 16 bits each, zero pad
    output logic        m_tlast    // last_row
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXIS,
        ST_REDUCE,
        ST_TRIG,
        ST_MUL,
        ST_OUT_LOAD,
        ST_OUT_SEND
    } state_t;

    state_t state_reg;

    logic signed [ANGLE_W-1:0] tgt_reg  [3];
    logic signed [PREV_W-1:0]  prev_reg [3];
    logic                      skip_reg;
    logic                      obank_reg, dbank_reg;
    logic                      oident_reg, dident_reg;
    logic [1:0]                axis_reg;
    logic                      final_reg;
    logic [DIFF_W-1:0]         mod_reg;
    logic signed [ELEM_W-1:0]  sin_reg, cos_reg;
    logic [3:0]                elem_reg;
    logic [2:0]                step_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic [1:0]                row_reg, col_reg;
    logic signed [ELEM_W-1:0]  orow_reg [4];

    logic signed [ELEM_W-1:0] orient_mem [32];
    logic signed [ELEM_W-1:0] delta_mem  [32];

    // Element indices of the current product
    logic [1:0] mi, mj, mk;
    assign mi = elem_reg[3:2];
    assign mj = elem_reg[1:0];
    assign mk = step_reg[1:0];

    // Angle difference of the current axis
    logic signed [DIFF_W-1:0] diff;
    assign diff = DIFF_W'(tgt_reg[axis_reg[1:0] == AXIS_DONE ? 2'd0 : axis_reg])
                - DIFF_W'(prev_reg[axis_reg[1:0] == AXIS_DONE ? 2'd0 : axis_reg]);

    // Orientation read port: one address, used by the product and the row output
    logic [4:0]               o_addr;
    logic signed [ELEM_W-1:0] o_rd, o_val;
    assign o_addr = (state_reg == ST_OUT_LOAD) ? {obank_reg, col_reg, row_reg}
                                               : {obank_reg, mi, mk};
    assign o_rd   = orient_mem[o_addr];
    always_comb begin
        if (oident_reg) begin
            o_val = (o_addr[3:2] == o_addr[1:0]) ? UNIT : '0;
        end else begin
            o_val = o_rd;
        end
    end

    // Delta read port
    logic signed [ELEM_W-1:0] d_rd, d_val;
    assign d_rd  = delta_mem[{dbank_reg, mk, mj}];
    assign d_val = dident_reg ? ((mk == mj) ? UNIT : '0) : d_rd;

    // Rotation matrix element (i, k) for the current axis
    logic signed [ELEM_W-1:0] r_val;
    always_comb begin
        r_val = (mi == mk) ? UNIT : '0;
        case (axis_reg)
            AXIS_X: begin
                if ((mi == 2'd1 && mk == 2'd1) || (mi == 2'd2 && mk == 2'd2)) r_val = cos_reg;
                if (mi == 2'd1 && mk == 2'd2) r_val = -sin_reg;
                if (mi == 2'd2 && mk == 2'd1) r_val = sin_reg;
            end
            AXIS_Y: begin
                if ((mi == 2'd0 && mk == 2'd0) || (mi == 2'd2 && mk == 2'd2)) r_val = cos_reg;
                if (mi == 2'd0 && mk == 2'd2) r_val = sin_reg;
                if (mi == 2'd2 && mk == 2'd0) r_val = -sin_reg;
            end
            AXIS_Z: begin
                if ((mi == 2'd0 && mk == 2'd0) || (mi == 2'd1 && mk == 2'd1)) r_val = cos_reg;
                if (mi == 2'd0 && mk == 2'd1) r_val = -sin_reg;
                if (mi == 2'd1 && mk == 2'd0) r_val = sin_reg;
            end
            default: begin
                r_val = (mi == mk) ? UNIT : '0;
            end
        endcase
    end

    // Shared multiplier operands
    logic signed [ELEM_W-1:0] op_a, op_b;
    assign op_a = final_reg ? o_val : r_val;
    assign op_b = d_val;

    // Rounded and saturated element
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [ELEM_W-1:0] res_elem;
    assign acc_sum  = acc_reg + ACC_W'(prod_reg) + HALF;
    assign res_elem = sat_elem(acc_sum >>> FRAC_BITS);

    // Quadrant folding for sine and cosine
    logic [6:0] a7;
    logic [8:0] ang;
    logic [6:0] idx_s, idx_c;
    logic       neg_s, neg_c;
    assign ang = mod_reg[8:0];
    assign a7  = '0;
    always_comb begin
        idx_s = a7;
        idx_c = a7;
        neg_s = 1'b0;
        neg_c = 1'b0;
        if (ang <= 9'd90) begin
            idx_s = 7'(ang);
            idx_c = 7'(9'd90 - ang);
        end else if (ang <= 9'd180) begin
            idx_s = 7'(9'd180 - ang);
            idx_c = 7'(ang - 9'd90);
            neg_c = 1'b1;
        end else if (ang <= 9'd270) begin
            idx_s = 7'(ang - 9'd180);
            idx_c = 7'(9'd270 - ang);
            neg_s = 1'b1;
            neg_c = 1'b1;
        end else begin
            idx_s = 7'(9'd360 - ang);
            idx_c = 7'(ang - 9'd270);
            neg_s = 1'b1;
        end
    end

    logic signed [ELEM_W-1:0] tab_s, tab_c;
    assign tab_s = SIN_T[idx_s];
    assign tab_c = SIN_T[idx_c];

    // Memory writes
    logic mul_write;
    assign mul_write = (state_reg == ST_MUL) && (step_reg == 3'd4);

    always_ff @(posedge aclk) begin
        if (mul_write && final_reg) begin
            orient_mem[{~obank_reg, elem_reg}] <= res_elem;
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_write && !final_reg) begin
            delta_mem[{~dbank_reg, elem_reg}] <= res_elem;
        end
    end

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            skip_reg   <= 1'b0;
            obank_reg  <= 1'b0;
            dbank_reg  <= 1'b0;
            oident_reg <= 1'b1;
            dident_reg <= 1'b1;
            axis_reg   <= AXIS_X;
            final_reg  <= 1'b0;
            elem_reg   <= '0;
            step_reg   <= '0;
            row_reg    <= '0;
            col_reg    <= '0;
            for (int n = 0; n < 3; n++) begin
                prev_reg[n] <= '0;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        if (s_tuser == REQ_RESET) begin
                            oident_reg <= 1'b1;
                            skip_reg   <= 1'b1;
                            for (int n = 0; n < 3; n++) begin
                                prev_reg[n] <= '0;
                            end
                        end else if (skip_reg) begin
                            skip_reg <= 1'b0;
                        end else begin
                            tgt_reg[0] <= s_tdata[9:0];
                            tgt_reg[1] <= s_tdata[19:10];
                            tgt_reg[2] <= s_tdata[29:20];
                            axis_reg   <= AXIS_X;
                            dident_reg <= 1'b1;
                            final_reg  <= 1'b0;
                            state_reg  <= ST_AXIS;
                        end
                    end
                end
                ST_AXIS: begin
                    elem_reg <= '0;
                    step_reg <= '0;
                    if (axis_reg == AXIS_DONE) begin
                        final_reg <= 1'b1;
                        state_reg <= ST_MUL;
                    end else if (diff == '0) begin
                        axis_reg <= axis_reg + 2'd1;
                    end else begin
                        mod_reg   <= diff + DIFF_BIAS;
                        state_reg <= ST_REDUCE;
                    end
                end
                ST_REDUCE: begin
                    if (mod_reg >= FULL_TURN) begin
                        mod_reg <= mod_reg - FULL_TURN;
                    end else begin
                        state_reg <= ST_TRIG;
                    end
                end
                ST_TRIG: begin
                    sin_reg   <= neg_s ? -tab_s : tab_s;
                    cos_reg   <= neg_c ? -tab_c : tab_c;
                    state_reg <= ST_MUL;
                end
                ST_MUL: begin
                    if (step_reg != 3'd4) begin
                        prod_reg <= op_a * op_b;
                        acc_reg  <= (step_reg == 3'd0) ? '0 : acc_reg + ACC_W'(prod_reg);
                        step_reg <= step_reg + 3'd1;
                    end else begin
                        step_reg <= '0;
                        elem_reg <= elem_reg + 4'd1;
                        if (elem_reg == 4'd15) begin
                            if (final_reg) begin
                                obank_reg  <= ~obank_reg;
                                oident_reg <= 1'b0;
                                for (int n = 0; n < 3; n++) begin
                                    prev_reg[n] <= PREV_W'(tgt_reg[n]);
                                end
                                row_reg   <= '0;
                                col_reg   <= '0;
                                state_reg <= ST_OUT_LOAD;
                            end else begin
                                dbank_reg  <= ~dbank_reg;
                                dident_reg <= 1'b0;
                                axis_reg   <= axis_reg + 2'd1;
                                state_reg  <= ST_AXIS;
                            end
                        end
                    end
                end
                ST_OUT_LOAD: begin
                    orow_reg[col_reg] <= o_val;
                    col_reg           <= col_reg + 2'd1;
                    if (col_reg == 2'd3) begin
                        state_reg <= ST_OUT_SEND;
                    end
                end
                ST_OUT_SEND: begin
                    if (m_tready) begin
                        col_reg <= '0;
                        if (row_reg == 2'd3) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            row_reg   <= row_reg + 2'd1;
                            state_reg <= ST_OUT_LOAD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT_SEND);
    assign m_tlast  = (row_reg == 2'd3);
    assign m_tdata  = {6'd0, orow_reg[3], orow_reg[2], orow_reg[1], orow_reg[0], row_reg};

    // Checks
    a_busy_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input and result sides active together");

    a_reduce_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_TRIG) |-> (mod_reg < FULL_TURN))
        else $error("angle not reduced below a full turn");

    a_row_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !m_tlast) |=> (row_reg == $past(row_reg) + 2'd1))
        else $error("row index did not advance");

    a_out_after_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (final_reg && !oident_reg))
        else $error("rows sent before final product");

endmodule
